>>> rtl/ccp_pkg.sv
// Shared types, field widths and constants of the container header parser.
package ccp_pkg;

  localparam int OFFSET_BITS_DEFAULT = 24;
  localparam int FIELD_OFF_W = 24;
  localparam int COUNTER_W = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNTER_W-1:0] LEN_BYTES = COUNTER_W'(3);
  localparam logic [COUNTER_W-1:0] TIME_BYTES = COUNTER_W'(4);
  localparam logic [COUNTER_W-1:0] RSVD_BYTES = COUNTER_W'(1);
  localparam logic [COUNTER_W-1:0] TIME_END = LEN_BYTES + TIME_BYTES;
  localparam logic [COUNTER_W-1:0] NAMELEN_POS = TIME_END + RSVD_BYTES;

  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [4:0] {
    PH_COUNT  = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_NAME   = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic                   kind;
    logic [7:0]             entry_index;
    logic [23:0]            file_length;
    logic [31:0]            modify_time;
    logic [FIELD_OFF_W-1:0] name_offset;
    logic [7:0]             name_length;
    logic [FIELD_OFF_W-1:0] data_offset;
    logic                   parse_ok;
    logic                   run_end;
  } result_t;

  // Parser state apart from the byte offset, whose width is a parameter.
  typedef struct packed {
    phase_t                 phase;
    logic [COUNTER_W-1:0]   field_counter;
    logic [7:0]             entry_number;
    logic [7:0]             total_files;
    logic [23:0]            length_accumulator;
    logic [31:0]            time_accumulator;
    logic                   final_header_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_COUNT,
    field_counter: '0,
    entry_number: '0,
    total_files: '0,
    length_accumulator: '0,
    time_accumulator: '0,
    final_header_seen: 1'b0
  };

  typedef struct packed {
    logic push_first;
    logic push_second;
  } push_ctl_t;

  typedef struct packed {
    logic                   room;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

>>> rtl/ccp_step.sv
// Next-state and result logic for one buffer byte.
module ccp_step #(
  parameter int OFFSET_BITS = ccp_pkg::OFFSET_BITS_DEFAULT
) (
  input  ccp_pkg::state_t    st,
  input  logic [OFFSET_BITS-1:0] byte_offset,
  input  ccp_pkg::item_t     item,
  output ccp_pkg::state_t    st_next,
  output logic [OFFSET_BITS-1:0] byte_offset_next,
  output ccp_pkg::result_t   desc,
  output logic               desc_valid,
  output ccp_pkg::result_t   stat,
  output logic               stat_valid
);
  import ccp_pkg::*;

  logic [OFFSET_BITS-1:0] noff;
  logic [OFFSET_BITS-1:0] doff;
  logic [31:0]            noff_w;
  logic [31:0]            doff_w;
  logic [COUNTER_W-1:0]   fc_dec;
  logic [7:0]             b;

  function automatic state_t next_entry(state_t s);
    state_t r;
    logic [7:0] en;
    r = s;
    en = s.entry_number + 8'd1;
    r.entry_number = en;
    if (en == 8'd0 || en >= s.total_files) begin
      r.phase = PH_DONE;
    end else begin
      r.phase = PH_HEADER;
      r.field_counter = '0;
    end
    return r;
  endfunction

  function automatic state_t start_data(state_t s);
    state_t r;
    r = s;
    if (s.length_accumulator != 24'd0) begin
      r.phase = PH_DATA;
      r.field_counter = COUNTER_W'(s.length_accumulator);
    end else begin
      r = next_entry(s);
    end
    return r;
  endfunction

  assign b = item.byte_value;
  assign noff = byte_offset + OFFSET_BITS'(1);
  assign doff = noff + OFFSET_BITS'(b);
  assign noff_w = 32'(noff);
  assign doff_w = 32'(doff);
  assign fc_dec = st.field_counter - COUNTER_W'(1);

  always_comb begin
    st_next = st;
    desc = '0;
    desc_valid = 1'b0;
    stat = '0;
    stat_valid = 1'b0;
    byte_offset_next = noff;
    unique case (st.phase)
      PH_COUNT: begin
        st_next.total_files = b;
        st_next.entry_number = '0;
        if (b == 8'd0) begin
          st_next.phase = PH_DONE;
        end else begin
          st_next.phase = PH_HEADER;
          st_next.field_counter = '0;
        end
      end
      PH_HEADER: begin
        if (st.field_counter == '0 &&
            ({1'b0, st.entry_number} + 9'd1) == {1'b0, st.total_files}) begin
          st_next.final_header_seen = 1'b1;
        end
        if (st.field_counter < LEN_BYTES) begin
          st_next.length_accumulator = (st.field_counter == '0) ? 24'(b)
                                     : {st.length_accumulator[15:0], b};
          st_next.field_counter = st.field_counter + COUNTER_W'(1);
        end else if (st.field_counter < TIME_END) begin
          st_next.time_accumulator = (st.field_counter == LEN_BYTES) ? 32'(b)
                                   : {st.time_accumulator[23:0], b};
          st_next.field_counter = st.field_counter + COUNTER_W'(1);
        end else if (st.field_counter < NAMELEN_POS) begin
          st_next.field_counter = st.field_counter + COUNTER_W'(1);
        end else begin
          desc_valid = 1'b1;
          desc.kind = KIND_DESC;
          desc.entry_index = st.entry_number;
          desc.file_length = st.length_accumulator;
          desc.modify_time = st.time_accumulator;
          desc.name_offset = noff_w[FIELD_OFF_W-1:0];
          desc.name_length = b;
          desc.data_offset = doff_w[FIELD_OFF_W-1:0];
          desc.parse_ok = 1'b0;
          desc.run_end = ~item.last_byte;
          if (b != 8'd0) begin
            st_next.phase = PH_NAME;
            st_next.field_counter = COUNTER_W'(b);
          end else begin
            st_next = start_data(st);
          end
        end
      end
      PH_NAME: begin
        st_next.field_counter = fc_dec;
        if (fc_dec == '0) begin
          st_next = start_data(st);
        end
      end
      PH_DATA: begin
        st_next.field_counter = fc_dec;
        if (fc_dec == '0) begin
          st_next = next_entry(st);
        end
      end
      PH_DONE: begin
        st_next = st;
      end
      default: begin
        st_next = st;
      end
    endcase
    if (item.last_byte) begin
      stat_valid = 1'b1;
      stat.kind = KIND_STATUS;
      stat.parse_ok = (st_next.total_files != 8'd0) && st_next.final_header_seen;
      stat.run_end = 1'b1;
      st_next = STATE_RESET;
      byte_offset_next = '0;
    end
  end

endmodule

>>> rtl/ccp_result_queue.sv
// Small result queue: up to two pushes and one pop per cycle.
module ccp_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  ccp_pkg::push_ctl_t    push,
  input  ccp_pkg::result_t      first,
  input  ccp_pkg::result_t      second,
  input  logic                  pop,
  output ccp_pkg::result_t      head,
  output logic                  head_valid,
  output ccp_pkg::queue_status_t status
);
  import ccp_pkg::*;

  result_t                entries [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic [QUEUE_IDX_W-1:0] wr_ptr_next;

  assign head = entries[rd_ptr];
  assign head_valid = (count != '0);
  // Room means space for the two results a byte may cause.
  assign status.room = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign status.count = count;

  always_comb begin
    count_next = count + QUEUE_CNT_W'(push.push_first) + QUEUE_CNT_W'(push.push_second)
               - QUEUE_CNT_W'(pop && head_valid);
    wr_ptr_next = wr_ptr + QUEUE_IDX_W'(push.push_first) + QUEUE_IDX_W'(push.push_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count <= count_next;
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + QUEUE_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_first) begin
      entries[wr_ptr] <= first;
    end
    if (push.push_second) begin
      entries[wr_ptr + QUEUE_IDX_W'(1)] <= second;
    end
  end

endmodule

>>> rtl/compound_container_header_parser_core.sv
// Top level of the compound container header parser.
//
// Feed the container buffer one byte per beat on the item channel; set
// last_byte on the final byte. Each header's name-length byte yields an
// entry descriptor beat (kind 0) on the result channel; the final byte
// yields a status beat (kind 1) carrying parse_ok, after the descriptor
// when one byte causes both. run_end marks the last result of a byte.
// After the final byte the parser returns to its start state, so the
// next byte opens a new buffer.
//
// A byte's first result passes through the input register, then the parse
// step into the result queue, before it is presented on the result channel.
// Throughput: one byte per cycle while the result queue has room; a byte
// that causes two results sends them in turn on the single-beat result port.
// The four-entry result queue lets input continue while results wait.
// A stalled receiver fills the queue; the byte register then holds and
// item_stall rises. Synchronous reset empties the queue and the byte
// register and puts the parser back in its count phase.
module compound_container_header_parser_core #(
  parameter int OFFSET_BITS = ccp_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ccp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ccp_pkg::result_t result
);
  import ccp_pkg::*;

  // Input register: holds one accepted byte until the parse step takes it.
  item_t item_q;
  logic  item_q_valid;
  logic  advance;

  // Parser state.
  state_t                 st;
  state_t                 st_next;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] byte_offset_next;

  result_t       desc;
  result_t       stat;
  logic          desc_valid;
  logic          stat_valid;
  push_ctl_t     push;
  result_t       first;
  queue_status_t q_status;

  // Advance the held byte only when the queue can absorb two results.
  assign advance = item_q_valid && q_status.room;
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  ccp_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .st              (st),
    .byte_offset     (byte_offset),
    .item            (item_q),
    .st_next         (st_next),
    .byte_offset_next(byte_offset_next),
    .desc            (desc),
    .desc_valid      (desc_valid),
    .stat            (stat),
    .stat_valid      (stat_valid)
  );

  // Update parser state once per consumed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
      byte_offset <= '0;
    end else if (advance) begin
      st <= st_next;
      byte_offset <= byte_offset_next;
    end
  end

  // Pack results so the descriptor goes first, then the status.
  assign push.push_first = advance && (desc_valid || stat_valid);
  assign push.push_second = advance && desc_valid && stat_valid;
  assign first = desc_valid ? desc : stat;

  ccp_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .first     (first),
    .second    (stat),
    .pop       (result_valid && !result_stall),
    .head      (result),
    .head_valid(result_valid),
    .status    (q_status)
  );

  // Never overfill the result queue.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A byte is consumed only when there is room for both possible results.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.push_first |-> q_status.room)
    else $error("push without room");

  // A status beat carries no entry detail.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_STATUS) |->
      (result.entry_index == 8'd0 && result.file_length == 24'd0 &&
       result.name_length == 8'd0 && result.run_end))
    else $error("status beat carries detail");

  // A descriptor never reports success.
  a_desc_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_DESC) |-> !result.parse_ok)
    else $error("descriptor with parse_ok");

  // Results are empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule
